>>> src/pzt_pkg.sv
// Shared types, constants and microcode encodings for the parking sensor zone tracker.
package pzt_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 3;
    localparam int LVL_W      = 2;
    localparam int DIST_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int HIGH_SHIFT = 5;
    localparam int STEP_W     = 3;

    localparam logic [DIST_W-1:0] NEAR_RESET = 14'd200;
    localparam logic [DIST_W-1:0] MID_RESET  = 14'd600;
    localparam logic [DIST_W-1:0] FAR_RESET  = 14'd1500;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR  = 2'd2;

    localparam logic [LVL_W-1:0] LVL_NEAREST = 2'd3;
    localparam logic [LVL_W-1:0] LVL_NEAR    = 2'd2;
    localparam logic [LVL_W-1:0] LVL_MID     = 2'd1;
    localparam logic [LVL_W-1:0] LVL_FAR     = 2'd0;

    localparam logic KIND_SENSOR = 1'b0;
    localparam logic KIND_SOUND  = 1'b1;

    typedef logic [LVL_W-1:0] t_level;

    typedef struct packed {
        logic              event_kind;
        logic [ADDR_W-1:0] sensor_id;
        t_level            level;
        logic              last;
    } t_event;

    localparam int EVENT_W = $bits(t_event);

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_ADDR     = 3'd0;
    localparam t_step STEP_HIGH     = 3'd1;
    localparam t_step STEP_LOW      = 3'd2;
    localparam t_step STEP_WRITE    = 3'd3;
    localparam t_step STEP_SOUND    = 3'd4;
    localparam t_step STEP_EMIT_LVL = 3'd5;
    localparam t_step STEP_EMIT_SND = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LATCH_ADDR,
        OP_LATCH_HIGH,
        OP_CLASSIFY,
        OP_WRITE_LVL,
        OP_SOUND,
        OP_EMIT_LVL,
        OP_EMIT_SND
    } t_op;

    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT
    } t_wait;

    typedef enum logic [1:0] {
        C_NEVER,
        C_ALWAYS,
        C_BAD_ADDR,
        C_NO_LVL_CHG
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_wait wait_on;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctrl;

    typedef struct packed {
        logic out_free;
        logic addr_bad;
        logic lvl_chg;
    } t_stat;

endpackage

>>> src/pzt_stream_if.sv
// Valid/ready stream interface carrying one word per handshake.
interface pzt_stream_if #(
    parameter int WIDTH = 8
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/pzt_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module pzt_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  pzt_pkg::t_stat i_stat,
    output pzt_pkg::t_ctrl o_ctrl
);

    function automatic pzt_pkg::t_uword ucode(input pzt_pkg::t_step s);
        pzt_pkg::t_uword w;
        w = '{pzt_pkg::OP_NOP, pzt_pkg::W_NONE, pzt_pkg::C_ALWAYS, pzt_pkg::STEP_ADDR};
        unique case (s)
            pzt_pkg::STEP_ADDR: w = '{pzt_pkg::OP_LATCH_ADDR, pzt_pkg::W_IN,
                                      pzt_pkg::C_BAD_ADDR, pzt_pkg::STEP_ADDR};
            pzt_pkg::STEP_HIGH: w = '{pzt_pkg::OP_LATCH_HIGH, pzt_pkg::W_IN,
                                      pzt_pkg::C_NEVER, pzt_pkg::STEP_ADDR};
            pzt_pkg::STEP_LOW: w = '{pzt_pkg::OP_CLASSIFY, pzt_pkg::W_IN,
                                     pzt_pkg::C_NEVER, pzt_pkg::STEP_ADDR};
            pzt_pkg::STEP_WRITE: w = '{pzt_pkg::OP_WRITE_LVL, pzt_pkg::W_NONE,
                                       pzt_pkg::C_NEVER, pzt_pkg::STEP_ADDR};
            pzt_pkg::STEP_SOUND: w = '{pzt_pkg::OP_SOUND, pzt_pkg::W_NONE,
                                       pzt_pkg::C_NO_LVL_CHG, pzt_pkg::STEP_EMIT_SND};
            pzt_pkg::STEP_EMIT_LVL: w = '{pzt_pkg::OP_EMIT_LVL, pzt_pkg::W_OUT,
                                          pzt_pkg::C_NEVER, pzt_pkg::STEP_ADDR};
            pzt_pkg::STEP_EMIT_SND: w = '{pzt_pkg::OP_EMIT_SND, pzt_pkg::W_OUT,
                                          pzt_pkg::C_ALWAYS, pzt_pkg::STEP_ADDR};
            default: w = '{pzt_pkg::OP_NOP, pzt_pkg::W_NONE,
                           pzt_pkg::C_ALWAYS, pzt_pkg::STEP_ADDR};
        endcase
        return w;
    endfunction

    pzt_pkg::t_step  r_pc;
    pzt_pkg::t_step  n_pc;
    pzt_pkg::t_uword w_word;
    logic            w_go;
    logic            w_jump;

    assign w_word = ucode(r_pc);

    always_comb begin
        unique case (w_word.wait_on)
            pzt_pkg::W_NONE: w_go = 1'b1;
            pzt_pkg::W_IN:   w_go = i_in_valid;
            pzt_pkg::W_OUT:  w_go = i_stat.out_free;
            default:         w_go = 1'b0;
        endcase
    end

    always_comb begin
        unique case (w_word.cond)
            pzt_pkg::C_NEVER:      w_jump = 1'b0;
            pzt_pkg::C_ALWAYS:     w_jump = 1'b1;
            pzt_pkg::C_BAD_ADDR:   w_jump = i_stat.addr_bad;
            pzt_pkg::C_NO_LVL_CHG: w_jump = !i_stat.lvl_chg;
            default:               w_jump = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (w_go) begin
            n_pc = w_jump ? w_word.target : r_pc + pzt_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pzt_pkg::STEP_ADDR;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op       = w_go ? w_word.op : pzt_pkg::OP_NOP;
    assign o_ctrl.in_ready = (w_word.wait_on == pzt_pkg::W_IN);

endmodule

>>> src/pzt_dp.sv
// Datapath: limit registers, frame registers, sensor levels, sound level and output register.
module pzt_dp #(
    parameter int SENSOR_COUNT = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pzt_pkg::t_ctrl                 i_ctrl,
    input  logic [pzt_pkg::BYTE_W-1:0]     i_byte,
    input  logic                           i_cfg_we,
    input  logic [pzt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pzt_pkg::DIST_W-1:0]     i_cfg_data,
    input  logic                           i_out_ready,
    output pzt_pkg::t_stat                 o_stat,
    output logic                           o_out_valid,
    output pzt_pkg::t_event                o_out_data
);

    logic [pzt_pkg::DIST_W-1:0] r_near;
    logic [pzt_pkg::DIST_W-1:0] r_mid;
    logic [pzt_pkg::DIST_W-1:0] r_far;

    logic [pzt_pkg::ADDR_W-1:0] r_addr;
    logic [pzt_pkg::BYTE_W-1:0] r_high;
    pzt_pkg::t_level            r_lvl_new;
    pzt_pkg::t_level            r_levels [SENSOR_COUNT];
    pzt_pkg::t_level            r_sound;
    logic                       r_lvl_chg;
    logic                       r_snd_chg;
    logic                       r_out_valid;
    pzt_pkg::t_event            r_out_data;

    logic [pzt_pkg::DIST_W-1:0] w_dist;
    pzt_pkg::t_level            w_class;
    logic [SENSOR_COUNT-1:0]    w_hit;
    logic                       w_differs;
    logic                       w_raised;
    pzt_pkg::t_level            w_raise_lvl;
    pzt_pkg::t_level            w_peak;
    logic                       w_out_free;

    // Distance is high*32 + low; it fits in 14 bits.
    assign w_dist = (pzt_pkg::DIST_W'(r_high) << pzt_pkg::HIGH_SHIFT)
                  + pzt_pkg::DIST_W'(i_byte);

    always_comb begin
        if (w_dist < r_near) begin
            w_class = pzt_pkg::LVL_NEAREST;
        end else if (w_dist < r_mid) begin
            w_class = pzt_pkg::LVL_NEAR;
        end else if (w_dist < r_far) begin
            w_class = pzt_pkg::LVL_MID;
        end else begin
            w_class = pzt_pkg::LVL_FAR;
        end
    end

    always_comb begin
        w_differs = 1'b0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            w_hit[i] = (r_addr == pzt_pkg::ADDR_W'(i + 1));
            if (w_hit[i] && (r_levels[i] != r_lvl_new)) begin
                w_differs = 1'b1;
            end
        end
    end

    // The lowest-numbered sensor above the sound level wins, so scan downward and overwrite.
    always_comb begin
        w_raised    = 1'b0;
        w_raise_lvl = pzt_pkg::LVL_FAR;
        w_peak      = pzt_pkg::LVL_FAR;
        for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
            if (r_levels[i] > r_sound) begin
                w_raised    = 1'b1;
                w_raise_lvl = r_levels[i];
            end
        end
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (r_levels[i] > w_peak) begin
                w_peak = r_levels[i];
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= pzt_pkg::NEAR_RESET;
            r_mid  <= pzt_pkg::MID_RESET;
            r_far  <= pzt_pkg::FAR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pzt_pkg::CFG_NEAR: r_near <= i_cfg_data;
                pzt_pkg::CFG_MID:  r_mid  <= i_cfg_data;
                pzt_pkg::CFG_FAR:  r_far  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            pzt_pkg::OP_LATCH_ADDR: r_addr    <= pzt_pkg::ADDR_W'(i_byte);
            pzt_pkg::OP_LATCH_HIGH: r_high    <= i_byte;
            pzt_pkg::OP_CLASSIFY:   r_lvl_new <= w_class;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_levels[i] <= pzt_pkg::LVL_FAR;
            end
            r_sound   <= pzt_pkg::LVL_FAR;
            r_lvl_chg <= 1'b0;
            r_snd_chg <= 1'b0;
        end else begin
            if (i_ctrl.op == pzt_pkg::OP_WRITE_LVL) begin
                r_lvl_chg <= w_differs;
                for (int i = 0; i < SENSOR_COUNT; i++) begin
                    if (w_hit[i]) begin
                        r_levels[i] <= r_lvl_new;
                    end
                end
            end
            if (i_ctrl.op == pzt_pkg::OP_SOUND) begin
                if (w_raised) begin
                    r_sound   <= w_raise_lvl;
                    r_snd_chg <= 1'b1;
                end else if (w_peak < r_sound) begin
                    r_sound   <= w_peak;
                    r_snd_chg <= 1'b1;
                end else begin
                    r_snd_chg <= 1'b0;
                end
            end
        end
    end

    // The sequencer only issues an emit when the output register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == pzt_pkg::OP_EMIT_LVL && r_lvl_chg) begin
            r_out_valid <= 1'b1;
            r_out_data  <= '{pzt_pkg::KIND_SENSOR, r_addr, r_lvl_new, !r_snd_chg};
        end else if (i_ctrl.op == pzt_pkg::OP_EMIT_SND && r_snd_chg) begin
            r_out_valid <= 1'b1;
            r_out_data  <= '{pzt_pkg::KIND_SOUND, pzt_pkg::ADDR_W'(0), r_sound, 1'b1};
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = w_out_free;
    assign o_stat.addr_bad = (i_byte == pzt_pkg::BYTE_W'(0))
                          || (i_byte > pzt_pkg::BYTE_W'(SENSOR_COUNT));
    assign o_stat.lvl_chg  = r_lvl_chg;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

>>> src/parking_sensor_zone_tracker.sv
// Top level of the parking sensor zone tracker: sequencer plus datapath.
//
//  channel | dir | word                                   | accepted when
//  --------+-----+----------------------------------------+------------------------
//  i_in    | in  | rx_byte[7:0]                           | i_in.valid & i_in.ready
//  o_out   | out | event_kind, sensor_id[2:0], level, last| o_out.valid & o_out.ready
//  cfg     | in  | i_cfg_idx selects limit, i_cfg_data    | i_cfg_we
//
// Each byte of a frame is taken in its own input step. After the low byte the
// sequencer runs the level write, the sound scan and one or two emit steps
// before it accepts the next address byte. Emit steps hold while the output
// register still carries an untaken word. Reset is synchronous and restores the
// default limits, clears all sensor levels and the sound level.
module parking_sensor_zone_tracker #(
    parameter int SENSOR_COUNT = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pzt_stream_if.sink                    i_in,
    pzt_stream_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [pzt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pzt_pkg::DIST_W-1:0]    i_cfg_data
);

    pzt_pkg::t_ctrl  w_ctrl;
    pzt_pkg::t_stat  w_stat;
    pzt_pkg::t_event w_out_data;
    logic            w_out_valid;

    // The sequencer walks the microprogram: address, high byte, low byte,
    // level write, sound update, level event, sound event.
    pzt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    // The datapath holds all state but the step counter and carries out one operation per step.
    pzt_dp #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_byte      (i_in.data[pzt_pkg::BYTE_W-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_stat      (w_stat),
        .o_out_valid (w_out_valid),
        .o_out_data  (w_out_data)
    );

    assign i_in.ready  = w_ctrl.in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_data;

endmodule

>>> src/pzt_checker.sv
// Port-level checker for the parking sensor zone tracker and its bind.
module pzt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pzt_pkg::EVENT_W-1:0] i_out_data
);

    pzt_pkg::t_event w_ev;
    assign w_ev = i_out_data;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output word changed while stalled");

    a_sound_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (w_ev.event_kind == pzt_pkg::KIND_SOUND)
            |-> (w_ev.sensor_id == pzt_pkg::ADDR_W'(0)) && w_ev.last)
        else $error("sound event must carry sensor 0 and be last");

    a_sensor_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (w_ev.event_kind == pzt_pkg::KIND_SENSOR)
            |-> (w_ev.sensor_id != pzt_pkg::ADDR_W'(0)))
        else $error("level event without a sensor address");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !w_ev.last
            |=> !(i_out_valid && (w_ev.event_kind == pzt_pkg::KIND_SENSOR)))
        else $error("a level event that is not last must be followed by a sound event");

endmodule

bind parking_sensor_zone_tracker pzt_checker u_pzt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> tb/tb_top.sv
// Self-checking testbench for the parking sensor zone tracker with a built-in frame tracker.
`timescale 1ns / 1ps

module tb_top;

    localparam int SENSOR_COUNT = 6;
    // Largest distance a well-formed frame can carry when the low byte stays in its five bits.
    localparam int MAX_BUILT_DIST = (1 << (pzt_pkg::BYTE_W + pzt_pkg::HIGH_SHIFT)) - 1;
    // Time for a frame to finish its level write, sound scan and emit steps after its low
    // byte once the output side has taken every word, with margin.
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_OFF_CYCLES = 300;

    // The spare index lies beyond the three limit registers and must be ignored.
    localparam logic [pzt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_HIGH,
        PH_LOW
    } t_phase;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [pzt_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [pzt_pkg::DIST_W-1:0]    i_cfg_data;

    pzt_stream_if #(.WIDTH(pzt_pkg::BYTE_W))  in_if ();
    pzt_stream_if #(.WIDTH(pzt_pkg::EVENT_W)) out_if ();

    parking_sensor_zone_tracker #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Frame tracker state. It mirrors what the block must hold: where we are in the
    // current frame, the latched address and high byte, one zone per sensor, the
    // warning-sound level and the three distance limits.
    t_phase                     trk_phase;
    logic [pzt_pkg::ADDR_W-1:0] trk_sensor;
    logic [pzt_pkg::BYTE_W-1:0] trk_high;
    pzt_pkg::t_level            trk_zone [1:SENSOR_COUNT];
    pzt_pkg::t_level            trk_sound;
    logic [pzt_pkg::DIST_W-1:0] lim_near;
    logic [pzt_pkg::DIST_W-1:0] lim_mid;
    logic [pzt_pkg::DIST_W-1:0] lim_far;

    // Event words the block still owes us, oldest first.
    pzt_pkg::t_event event_q [$];

    // Idle and stall control shared between the stimulus and the output sink.
    int unsigned src_gap_max = 16;
    int unsigned sink_gap_max = 16;
    int unsigned sink_hold_cycles = 0;

    int fail_count = 0;
    int events_checked = 0;
    int bytes_sent = 0;
    int frames_sent = 0;

    // Sort a distance into a zone. The tests run nearest first, so limits that are
    // out of order simply lose to the earlier test.
    function automatic pzt_pkg::t_level zone_of(input logic [pzt_pkg::DIST_W-1:0] span);
        if (span < lim_near) return pzt_pkg::LVL_NEAREST;
        if (span < lim_mid) return pzt_pkg::LVL_NEAR;
        if (span < lim_far) return pzt_pkg::LVL_MID;
        return pzt_pkg::LVL_FAR;
    endfunction

    function automatic pzt_pkg::t_event make_event(input logic kind,
                                                   input logic [pzt_pkg::ADDR_W-1:0] id,
                                                   input pzt_pkg::t_level lvl);
        pzt_pkg::t_event ev;
        ev.event_kind = kind;
        ev.sensor_id  = id;
        ev.level      = lvl;
        ev.last       = 1'b0;
        return ev;
    endfunction

    // Advance the frame tracker by one accepted byte and queue the event words it causes.
    task automatic track_byte(input logic [pzt_pkg::BYTE_W-1:0] b);
        pzt_pkg::t_event            fresh [2];
        int                         n;
        pzt_pkg::t_level            lvl;
        pzt_pkg::t_level            peak;
        logic                       raised;
        logic [pzt_pkg::DIST_W-1:0] span;
        n = 0;
        case (trk_phase)
            PH_HIGH: begin
                trk_high  = b;
                trk_phase = PH_LOW;
            end
            PH_LOW: begin
                trk_phase = PH_ADDR;
                span = (pzt_pkg::DIST_W'(trk_high) << pzt_pkg::HIGH_SHIFT)
                     + pzt_pkg::DIST_W'(b);
                lvl  = zone_of(span);
                if (trk_zone[trk_sensor] != lvl) begin
                    trk_zone[trk_sensor] = lvl;
                    fresh[n] = make_event(pzt_pkg::KIND_SENSOR, trk_sensor, lvl);
                    n++;
                end
                // The first sensor, scanned upward, that beats the sound level wins.
                // Otherwise the sound level may only drop to the highest stored zone.
                raised = 1'b0;
                peak   = pzt_pkg::LVL_FAR;
                for (int s = 1; s <= SENSOR_COUNT; s++) begin
                    if (!raised) begin
                        if (trk_zone[s] > trk_sound) begin
                            trk_sound = trk_zone[s];
                            raised    = 1'b1;
                        end else if (trk_zone[s] > peak) begin
                            peak = trk_zone[s];
                        end
                    end
                end
                if (raised) begin
                    fresh[n] = make_event(pzt_pkg::KIND_SOUND, '0, trk_sound);
                    n++;
                end else if (peak < trk_sound) begin
                    trk_sound = peak;
                    fresh[n] = make_event(pzt_pkg::KIND_SOUND, '0, trk_sound);
                    n++;
                end
                if (n > 0) fresh[n-1].last = 1'b1;
                for (int k = 0; k < n; k++) event_q.push_back(fresh[k]);
            end
            default: begin
                // Idle: only a valid sensor address opens a frame, anything else is dropped.
                trk_phase = PH_ADDR;
                if (b >= 1 && b <= SENSOR_COUNT) begin
                    trk_sensor = b[pzt_pkg::ADDR_W-1:0];
                    trk_phase  = PH_HIGH;
                end
            end
        endcase
    endtask

    // Offer one byte after a random gap and hold it until the block takes it. The
    // valid line is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_byte(input logic [pzt_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            in_if.data  <= pzt_pkg::BYTE_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        track_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [pzt_pkg::BYTE_W-1:0] addr,
                              input logic [pzt_pkg::BYTE_W-1:0] high,
                              input logic [pzt_pkg::BYTE_W-1:0] low);
        send_byte(addr);
        send_byte(high);
        send_byte(low);
        frames_sent++;
    endtask

    // A well-formed frame to a random sensor. Four in ten distances sit near one of the
    // current limits so the zones keep changing; as many are spread up to 2000, and the
    // rest are raw byte pairs so that the upper bits of the low byte get exercised too.
    task automatic send_random_frame();
        int                         sel;
        int                         span;
        logic [pzt_pkg::DIST_W-1:0] lim;
        logic [pzt_pkg::BYTE_W-1:0] addr;
        addr = pzt_pkg::BYTE_W'($urandom_range(1, SENSOR_COUNT));
        sel  = $urandom_range(0, 9);
        if (sel < 2) begin
            send_frame(addr, pzt_pkg::BYTE_W'($urandom), pzt_pkg::BYTE_W'($urandom));
        end else begin
            if (sel < 6) begin
                case ($urandom_range(0, 2))
                    0:       lim = lim_near;
                    1:       lim = lim_mid;
                    default: lim = lim_far;
                endcase
                span = int'(lim) + int'($urandom_range(0, 16)) - 8;
            end else begin
                span = $urandom_range(0, 2000);
            end
            if (span < 0) span = 0;
            if (span > MAX_BUILT_DIST) span = MAX_BUILT_DIST;
            send_frame(addr, pzt_pkg::BYTE_W'(span >> pzt_pkg::HIGH_SHIFT),
                       pzt_pkg::BYTE_W'(span % (1 << pzt_pkg::HIGH_SHIFT)));
        end
    endtask

    // A byte that the block must drop while idle: zero or anything above the last sensor.
    function automatic logic [pzt_pkg::BYTE_W-1:0] noise_byte();
        if ($urandom_range(0, 3) == 0) return '0;
        return pzt_pkg::BYTE_W'($urandom_range(SENSOR_COUNT + 1, 255));
    endfunction

    // Stop offering, wait for every owed word, then give a frame that ends without
    // any event time to finish before the caller touches the limits.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three limits plus the spare index, one register per cycle.
    task automatic write_limits(input logic [pzt_pkg::DIST_W-1:0] near_v,
                                input logic [pzt_pkg::DIST_W-1:0] mid_v,
                                input logic [pzt_pkg::DIST_W-1:0] far_v);
        logic [pzt_pkg::CFG_IDX_W-1:0] idx_list [4];
        logic [pzt_pkg::DIST_W-1:0]    val_list [4];
        idx_list = '{pzt_pkg::CFG_NEAR, pzt_pkg::CFG_MID, pzt_pkg::CFG_FAR, CFG_SPARE};
        val_list = '{near_v, mid_v, far_v, pzt_pkg::DIST_W'($urandom)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= val_list[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        lim_near = near_v;
        lim_mid  = mid_v;
        lim_far  = far_v;
    endtask

    // Hand-picked frames: dropped idle bytes, the distance extremes, both sides of
    // the near limit, data bytes that look like addresses, and the sound level
    // rising on the first higher sensor and falling back to the highest zone.
    task automatic test_directed_frames();
        send_byte(8'd0);
        send_byte(8'd7);
        send_byte(8'hFF);
        send_frame(8'd1, 8'd0, 8'd0);       // distance 0, sound jumps to nearest
        send_frame(8'd2, 8'd6, 8'd7);       // 199, one below the near limit
        send_frame(8'd3, 8'd6, 8'd8);       // 200, high byte reads like sensor 6
        send_frame(8'd1, 8'hFF, 8'hFF);     // 8415, the largest distance
        send_frame(8'd2, 8'd46, 8'd27);     // 1499, sound falls to the highest zone
        send_frame(8'd3, 8'd46, 8'd28);     // 1500 is far, sound falls again
        send_frame(8'd5, 8'd0, 8'd5);       // low byte reads like sensor 5
        settle();
    endtask

    task automatic run_setting(input logic [pzt_pkg::DIST_W-1:0] near_v,
                               input logic [pzt_pkg::DIST_W-1:0] mid_v,
                               input logic [pzt_pkg::DIST_W-1:0] far_v, input int frames);
        write_limits(near_v, mid_v, far_v);
        repeat (frames) send_random_frame();
        settle();
    endtask

    // Sweep the limits through their extremes, an inverted order, random sorted and
    // unsorted sets, and finally back to the reset values.
    task automatic test_limit_settings();
        logic [pzt_pkg::DIST_W-1:0] a;
        logic [pzt_pkg::DIST_W-1:0] b;
        logic [pzt_pkg::DIST_W-1:0] c;
        run_setting('0, '0, '0, 30);
        run_setting('1, '1, '1, 30);
        run_setting(14'd1000, 14'd500, 14'd100, 30);
        a = pzt_pkg::DIST_W'($urandom_range(0, 1000));
        b = a + pzt_pkg::DIST_W'($urandom_range(0, 1500));
        c = b + pzt_pkg::DIST_W'($urandom_range(0, 3000));
        run_setting(a, b, c, 30);
        run_setting(pzt_pkg::DIST_W'($urandom), pzt_pkg::DIST_W'($urandom),
                    pzt_pkg::DIST_W'($urandom), 30);
        run_setting(pzt_pkg::NEAR_RESET, pzt_pkg::MID_RESET, pzt_pkg::FAR_RESET, 30);
    endtask

    // Long random run, mostly clean frames, with idle noise and stray addresses that
    // knock the framing out of step. Idling on both sides changes every 60 frames,
    // with stretches where neither side pauses at all.
    task automatic test_random_traffic(input int frames);
        for (int f = 0; f < frames; f++) begin
            if (f % 60 == 0) begin
                src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 16;
                sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            end
            case ($urandom_range(0, 19))
                0, 1: repeat ($urandom_range(1, 3)) send_byte(noise_byte());
                2: send_byte(pzt_pkg::BYTE_W'($urandom_range(1, SENSOR_COUNT)));
                default: ;
            endcase
            send_random_frame();
        end
        settle();
        src_gap_max  = 16;
        sink_gap_max = 16;
    endtask

    // The sink stops taking words for a long stretch while frames keep coming at
    // full rate, so the output register fills and the block must stall its input.
    task automatic test_output_stall();
        src_gap_max      = 0;
        sink_hold_cycles = HOLD_OFF_CYCLES;
        repeat (40) send_random_frame();
        settle();
        src_gap_max = 16;
    endtask

    // Output sink: draws a wait before each word, or takes a requested long hold-off
    // that it counts out itself. Ready stays high across back-to-back words.
    initial begin : event_sink
        int unsigned wait_n;
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                wait_n           = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                wait_n = $urandom_range(0, sink_gap_max);
            end
            if (wait_n > 0) begin
                out_if.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    // Every accepted event word is matched field by field against the oldest owed one.
    always @(posedge i_clk) begin : event_check
        pzt_pkg::t_event seen;
        pzt_pkg::t_event want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            seen = out_if.data;
            if (event_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected event word: kind %0d sensor %0d level %0d last %0d",
                             $realtime, seen.event_kind, seen.sensor_id, seen.level, seen.last);
            end else begin
                want = event_q.pop_front();
                events_checked++;
                if (seen.event_kind !== want.event_kind || seen.sensor_id !== want.sensor_id ||
                    seen.level !== want.level || seen.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: event mismatch: expected kind %0d sensor %0d level %0d last %0d",
                                 $realtime, want.event_kind, want.sensor_id, want.level,
                                 want.last);
                        $display("    got kind %0d sensor %0d level %0d last %0d",
                                 seen.event_kind, seen.sensor_id, seen.level, seen.last);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= pzt_pkg::CFG_NEAR;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        trk_phase  = PH_ADDR;
        trk_sensor = '0;
        trk_high   = '0;
        trk_sound  = pzt_pkg::LVL_FAR;
        for (int s = 1; s <= SENSOR_COUNT; s++) trk_zone[s] = pzt_pkg::LVL_FAR;
        lim_near = pzt_pkg::NEAR_RESET;
        lim_mid  = pzt_pkg::MID_RESET;
        lim_far  = pzt_pkg::FAR_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_limit_settings();
        test_output_stall();
        test_random_traffic(220);

        settle();
        $display("Covered %0d frames in %0d accepted bytes over six limit settings, idle noise,",
                 frames_sent, bytes_sent);
        $display("misaligned framing and a long output hold-off; %0d event words checked.",
                 events_checked);
        if (fail_count == 0 && event_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d event words never arrived", fail_count, event_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: a correct run finishes far earlier than this.
    initial begin : watchdog
        #(5_000_000);
        $display("Timeout with %0d event words still owed", event_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
